### design/pwli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwli_pkg
// shared types, constants and microcode program of the piecewise linear
// interpolator
// ----------------------------------------------------------------------------
package pwli_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int DATA_W         = 32;
  localparam int NP_W           = 5;
  localparam int SLOT_W         = 4;
  localparam int PC_W           = 4;
  localparam int DIV_CNT_W      = $clog2(DATA_W + 1);

  // region codes on the result
  localparam logic [1:0] REGION_INTERIOR = 2'd0;
  localparam logic [1:0] REGION_LOW      = 2'd1;
  localparam logic [1:0] REGION_HIGH     = 2'd2;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // microcode step addresses
  localparam logic [PC_W-1:0] PC_INIT       = 4'd0;
  localparam logic [PC_W-1:0] PC_PROBE      = 4'd1;
  localparam logic [PC_W-1:0] PC_CMP        = 4'd2;
  localparam logic [PC_W-1:0] PC_SELECT     = 4'd3;
  localparam logic [PC_W-1:0] PC_LOAD0      = 4'd4;
  localparam logic [PC_W-1:0] PC_LOAD1      = 4'd5;
  localparam logic [PC_W-1:0] PC_PREP       = 4'd6;
  localparam logic [PC_W-1:0] PC_MUL        = 4'd7;
  localparam logic [PC_W-1:0] PC_DIV        = 4'd8;
  localparam logic [PC_W-1:0] PC_OUT_INTERP = 4'd9;
  localparam logic [PC_W-1:0] PC_OUT_EDGE   = 4'd10;
  localparam logic [PC_W-1:0] PC_LAST       = PC_OUT_EDGE;

  // table read address source
  typedef enum logic [1:0] {
    RD_NONE,
    RD_MID,
    RD_PICK,
    RD_LO
  } rd_sel_t;

  // datapath action
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_INIT,
    ACT_SEARCH,
    ACT_REGION,
    ACT_LATCH0,
    ACT_LATCH1,
    ACT_PREP,
    ACT_MUL,
    ACT_DIV,
    ACT_OUT_INTERP,
    ACT_OUT_EDGE
  } act_t;

  // jump condition
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_SEARCH_DONE,
    COND_EDGE,
    COND_DEN_ZERO,
    COND_DIV_MORE
  } cond_t;

  typedef struct packed {
    rd_sel_t         rd;
    act_t            act;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            last;
  } ucode_t;

  typedef struct packed {
    logic    load;
    logic    query;
    rd_sel_t rd;
    act_t    act;
  } ctrl_t;

  typedef struct packed {
    logic search_done;
    logic edge_hit;
    logic den_zero;
    logic div_more;
  } status_t;

  // control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      PC_INIT:       w = '{RD_NONE, ACT_INIT,       COND_NEXT,        PC_INIT,       1'b0};
      PC_PROBE:      w = '{RD_MID,  ACT_NONE,       COND_SEARCH_DONE, PC_SELECT,     1'b0};
      PC_CMP:        w = '{RD_NONE, ACT_SEARCH,     COND_JUMP,        PC_PROBE,      1'b0};
      PC_SELECT:     w = '{RD_PICK, ACT_REGION,     COND_NEXT,        PC_INIT,       1'b0};
      PC_LOAD0:      w = '{RD_LO,   ACT_LATCH0,     COND_EDGE,        PC_OUT_EDGE,   1'b0};
      PC_LOAD1:      w = '{RD_NONE, ACT_LATCH1,     COND_NEXT,        PC_INIT,       1'b0};
      PC_PREP:       w = '{RD_NONE, ACT_PREP,       COND_DEN_ZERO,    PC_OUT_INTERP, 1'b0};
      PC_MUL:        w = '{RD_NONE, ACT_MUL,        COND_NEXT,        PC_INIT,       1'b0};
      PC_DIV:        w = '{RD_NONE, ACT_DIV,        COND_DIV_MORE,    PC_DIV,        1'b0};
      PC_OUT_INTERP: w = '{RD_NONE, ACT_OUT_INTERP, COND_NEXT,        PC_INIT,       1'b1};
      PC_OUT_EDGE:   w = '{RD_NONE, ACT_OUT_EDGE,   COND_NEXT,        PC_INIT,       1'b1};
      default:       w = '{RD_NONE, ACT_NONE,       COND_NEXT,        PC_INIT,       1'b1};
    endcase
    return w;
  endfunction

  // magnitude of a 33-bit difference of two 32-bit values
  function automatic logic [DATA_W-1:0] mag33(input logic signed [DATA_W:0] v);
    logic [DATA_W:0] t;
    t = v[DATA_W] ? -v : v;
    return t[DATA_W-1:0];
  endfunction

endpackage

### design/pwli_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwli_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module pwli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/pwli_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwli_seq
// step counter and microcode sequencer, drives the datapath control word
// ----------------------------------------------------------------------------
module pwli_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              kind,
  input  pwli_pkg::status_t status,
  output logic              busy,
  output pwli_pkg::ctrl_t   ctrl
);

  logic [pwli_pkg::PC_W-1:0] pc;
  pwli_pkg::ucode_t          cw;
  logic                      accept;
  logic                      cond_ok;

  assign accept = start && !busy;
  assign cw     = pwli_pkg::ucode_rom(pc);

  always_comb begin
    unique case (cw.cond)
      pwli_pkg::COND_NEXT:        cond_ok = 1'b0;
      pwli_pkg::COND_JUMP:        cond_ok = 1'b1;
      pwli_pkg::COND_SEARCH_DONE: cond_ok = status.search_done;
      pwli_pkg::COND_EDGE:        cond_ok = status.edge_hit;
      pwli_pkg::COND_DEN_ZERO:    cond_ok = status.den_zero;
      pwli_pkg::COND_DIV_MORE:    cond_ok = status.div_more;
      default:                    cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    ctrl.load  = accept && (kind == pwli_pkg::KIND_LOAD);
    ctrl.query = accept && (kind == pwli_pkg::KIND_QUERY);
    ctrl.rd    = busy ? cw.rd : pwli_pkg::RD_NONE;
    ctrl.act   = busy ? cw.act : pwli_pkg::ACT_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= pwli_pkg::PC_INIT;
    end else if (ctrl.query) begin
      busy <= 1'b1;
      pc   <= pwli_pkg::PC_INIT;
    end else if (busy) begin
      if (cw.last) begin
        busy <= 1'b0;
        pc   <= pwli_pkg::PC_INIT;
      end else if (cond_ok) begin
        pc <= cw.target;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pc <= pwli_pkg::PC_LAST)
    else $error("step counter beyond program");

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    ctrl.query |=> busy && pc == pwli_pkg::PC_INIT)
    else $error("query did not start program");
`endif

endmodule

### design/pwli_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwli_datapath
// breakpoint tables, search bounds, multiply and serial divide datapath
// ----------------------------------------------------------------------------
module pwli_datapath #(
  parameter int MAX_POINTS = pwli_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pwli_pkg::ctrl_t                     ctrl,
  input  logic [pwli_pkg::SLOT_W-1:0]         point_index,
  input  logic signed [pwli_pkg::DATA_W-1:0]  x_value,
  input  logic signed [pwli_pkg::DATA_W-1:0]  y_value,
  input  logic                                num_points_we,
  input  logic [pwli_pkg::NP_W-1:0]           num_points,
  output pwli_pkg::status_t                   status,
  output logic                                done,
  output logic signed [pwli_pkg::DATA_W-1:0]  y_result,
  output logic [1:0]                          region
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int DW    = pwli_pkg::DATA_W;

  logic [pwli_pkg::NP_W-1:0]       np_reg;
  logic [CNT_W-1:0]                eff_n;
  logic [CNT_W-1:0]                lo;
  logic [CNT_W-1:0]                hi;
  logic [CNT_W:0]                  lo_hi_sum;
  logic [CNT_W-1:0]                mid;
  logic [IDX_W-1:0]                raddr;
  logic                            wr_en;
  logic [DW-1:0]                   rd_x;
  logic [DW-1:0]                   rd_y;
  logic signed [DW-1:0]            x_q;
  logic signed [DW-1:0]            x0;
  logic signed [DW-1:0]            y0;
  logic signed [DW:0]              dx;
  logic signed [DW:0]              dy;
  logic signed [DW:0]              den;
  logic [DW-1:0]                   amag;
  logic [DW-1:0]                   bmag;
  logic [DW-1:0]                   dmag;
  logic                            neg;
  logic [DW-1:0]                   rem;
  logic [DW-1:0]                   quot;
  logic [pwli_pkg::DIV_CNT_W-1:0]  cnt;
  logic [1:0]                      region_q;
  logic [DW:0]                     shifted;
  logic [DW:0]                     trial;
  logic                            fits;
  logic [DW-1:0]                   qc;
  logic signed [DW+1:0]            qs;
  logic signed [DW+1:0]            sum;
  logic                            sat_hi;
  logic                            sat_lo;
  logic [DW-1:0]                   interp;

  // clamp the breakpoint count into 1..MAX_POINTS
  always_comb begin
    if (np_reg == '0) begin
      eff_n = CNT_W'(1);
    end else if (int'(np_reg) > MAX_POINTS) begin
      eff_n = CNT_W'(MAX_POINTS);
    end else begin
      eff_n = CNT_W'(np_reg);
    end
  end

  assign lo_hi_sum = {1'b0, lo} + {1'b0, hi};
  assign mid       = lo_hi_sum[CNT_W:1];
  assign wr_en     = ctrl.load && (int'(point_index) < MAX_POINTS);

  always_comb begin
    unique case (ctrl.rd)
      pwli_pkg::RD_MID:  raddr = IDX_W'(mid);
      pwli_pkg::RD_LO:   raddr = IDX_W'(lo);
      pwli_pkg::RD_PICK: begin
        if (lo == '0) begin
          raddr = '0;
        end else if (lo >= eff_n) begin
          raddr = IDX_W'(eff_n - 1'b1);
        end else begin
          raddr = IDX_W'(lo - 1'b1);
        end
      end
      default:           raddr = '0;
    endcase
  end

  pwli_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk   (clk),
    .we    (wr_en),
    .waddr (IDX_W'(point_index)),
    .wdata (x_value),
    .raddr (raddr),
    .rdata (rd_x)
  );

  pwli_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk   (clk),
    .we    (wr_en),
    .waddr (IDX_W'(point_index)),
    .wdata (y_value),
    .raddr (raddr),
    .rdata (rd_y)
  );

  // one restoring divide step
  assign shifted = {rem, quot[DW-1]};
  assign trial   = shifted - {1'b0, dmag};
  assign fits    = shifted >= {1'b0, dmag};

  // sign, add and saturate
  always_comb begin
    qc     = (quot > {1'b1, {(DW-1){1'b0}}}) ? {1'b1, {(DW-1){1'b0}}} : quot;
    qs     = neg ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
    sum    = $signed({{2{y0[DW-1]}}, y0}) + qs;
    sat_hi = !sum[DW+1] && (sum[DW:DW-1] != 2'b00);
    sat_lo = sum[DW+1] && (sum[DW:DW-1] != 2'b11);
    if (sat_hi) begin
      interp = {1'b0, {(DW-1){1'b1}}};
    end else if (sat_lo) begin
      interp = {1'b1, {(DW-1){1'b0}}};
    end else begin
      interp = sum[DW-1:0];
    end
  end

  always_comb begin
    status.search_done = lo >= hi;
    status.edge_hit    = region_q != pwli_pkg::REGION_INTERIOR;
    status.den_zero    = den == '0;
    status.div_more    = cnt != pwli_pkg::DIV_CNT_W'(1);
  end

  // configuration and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      np_reg <= pwli_pkg::NP_W'(1);
      done   <= 1'b0;
    end else begin
      if (num_points_we) begin
        np_reg <= num_points;
      end
      done <= (ctrl.act == pwli_pkg::ACT_OUT_INTERP) || (ctrl.act == pwli_pkg::ACT_OUT_EDGE);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.query) begin
      x_q <= x_value;
    end
    unique case (ctrl.act)
      pwli_pkg::ACT_INIT: begin
        lo <= '0;
        hi <= eff_n;
      end
      pwli_pkg::ACT_SEARCH: begin
        if ($signed(rd_x) < x_q) begin
          lo <= mid + 1'b1;
        end else begin
          hi <= mid;
        end
      end
      pwli_pkg::ACT_REGION: begin
        if (lo == '0) begin
          region_q <= pwli_pkg::REGION_LOW;
        end else if (lo >= eff_n) begin
          region_q <= pwli_pkg::REGION_HIGH;
        end else begin
          region_q <= pwli_pkg::REGION_INTERIOR;
        end
      end
      pwli_pkg::ACT_LATCH0: begin
        x0 <= rd_x;
        y0 <= rd_y;
      end
      pwli_pkg::ACT_LATCH1: begin
        dx  <= {x_q[DW-1], x_q} - {x0[DW-1], x0};
        den <= $signed({rd_x[DW-1], rd_x}) - {x0[DW-1], x0};
        dy  <= $signed({rd_y[DW-1], rd_y}) - {y0[DW-1], y0};
      end
      pwli_pkg::ACT_PREP: begin
        amag <= pwli_pkg::mag33(dx);
        bmag <= pwli_pkg::mag33(dy);
        dmag <= pwli_pkg::mag33(den);
        neg  <= dx[DW] ^ dy[DW] ^ den[DW];
        quot <= '0;
      end
      pwli_pkg::ACT_MUL: begin
        {rem, quot} <= amag * bmag;
        cnt         <= pwli_pkg::DIV_CNT_W'(DW);
      end
      pwli_pkg::ACT_DIV: begin
        rem  <= fits ? trial[DW-1:0] : shifted[DW-1:0];
        quot <= {quot[DW-2:0], fits};
        cnt  <= cnt - 1'b1;
      end
      pwli_pkg::ACT_OUT_INTERP: begin
        y_result <= interp;
        region   <= region_q;
      end
      pwli_pkg::ACT_OUT_EDGE: begin
        y_result <= y0;
        region   <= region_q;
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (ctrl.act == pwli_pkg::ACT_DIV) |-> rem < dmag)
    else $error("divide remainder not below divisor");
`endif

endmodule

### design/piecewise_linear_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_top
// piecewise linear interpolation over a loaded table of q16.16 breakpoints,
// run by a microcoded sequencer over a shared search, multiply and divide
// datapath
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  --------  ------------------------  -----------------------------------
//  item in   start / busy              kind, point_index, x_value, y_value
//  result    done (one-cycle strobe)   y_result, region
//  config    num_points_we             num_points
//
//  a load is a single transfer: the slot is written at the accepting
//  edge and busy stays low
//  a query runs the microcode program: a halving search of up to 5 steps
//  for sixteen points, then, in the interior and for a segment of nonzero
//  width, a multiply and a 32-step serial divide; at or outside the table
//  ends the search result goes straight to the output step
//  done rises in the same cycle as busy falls, so the next item can be taken
//  while the result is shown; the receiver cannot stall the result
//  synchronous active-high reset clears the sequencer and sets num_points
//  to one; table contents are not cleared
//
module piecewise_linear_interpolator_top #(
  parameter int MAX_POINTS = pwli_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // item transfer
  input  logic                                start,
  output logic                                busy,
  input  logic                                kind,
  input  logic [pwli_pkg::SLOT_W-1:0]         point_index,
  input  logic signed [pwli_pkg::DATA_W-1:0]  x_value,
  input  logic signed [pwli_pkg::DATA_W-1:0]  y_value,
  // configuration write
  input  logic                                num_points_we,
  input  logic [pwli_pkg::NP_W-1:0]           num_points,
  // result
  output logic                                done,
  output logic signed [pwli_pkg::DATA_W-1:0]  y_result,
  output logic [1:0]                          region
);

  pwli_pkg::ctrl_t   ctrl;
  pwli_pkg::status_t status;

  // program counter and control store
  pwli_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  // tables, search bounds and arithmetic
  pwli_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .point_index   (point_index),
    .x_value       (x_value),
    .y_value       (y_value),
    .num_points_we (num_points_we),
    .num_points    (num_points),
    .status        (status),
    .done          (done),
    .y_result      (y_result),
    .region        (region)
  );

`ifndef NO_ASSERTIONS
  // a result only appears once the query program has finished
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // every finished query yields exactly one result transfer
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("query ended without result");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the piecewise linear interpolator: a directed table
// of loads, queries and breakpoint-count writes, then random table phases
// with queries aimed at the breakpoints, each result checked in order against
// a typed expected value or an in-bench interpolation model
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TBL_DEPTH      = pwli_pkg::MAX_POINTS_DEF;
  localparam int ITEM_TARGET    = 800;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 60;
  localparam int MAX_REPORTS    = 100;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_QUERY,
    ROW_POINTS
  } row_op_t;

  typedef struct packed {
    logic signed [pwli_pkg::DATA_W-1:0] y;
    logic [1:0]                         region;
  } interp_t;

  typedef struct {
    row_op_t                            op;
    logic [pwli_pkg::SLOT_W-1:0]        slot;
    logic signed [pwli_pkg::DATA_W-1:0] x;
    logic signed [pwli_pkg::DATA_W-1:0] y;
    bit                                 typed;
    interp_t                            res;
  } stim_row_t;

  // block ports
  logic                               clk;
  logic                               rst;
  logic                               start;
  logic                               busy;
  logic                               kind;
  logic [pwli_pkg::SLOT_W-1:0]        point_index;
  logic signed [pwli_pkg::DATA_W-1:0] x_value;
  logic signed [pwli_pkg::DATA_W-1:0] y_value;
  logic                               num_points_we;
  logic [pwli_pkg::NP_W-1:0]          num_points;
  logic                               done;
  logic signed [pwli_pkg::DATA_W-1:0] y_result;
  logic [1:0]                         region;

  // bench copy of the breakpoint table and the count register
  logic signed [pwli_pkg::DATA_W-1:0] bp_x [TBL_DEPTH];
  logic signed [pwli_pkg::DATA_W-1:0] bp_y [TBL_DEPTH];
  logic [pwli_pkg::NP_W-1:0]          points_reg;

  interp_t   expected_q [$];
  interp_t   oldest;
  stim_row_t dir_rows [$];
  int        errors;
  int        items_sent;
  int        stall_cycles;

  piecewise_linear_interpolator_top u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .point_index   (point_index),
    .x_value       (x_value),
    .y_value       (y_value),
    .num_points_we (num_points_we),
    .num_points    (num_points),
    .done          (done),
    .y_result      (y_result),
    .region        (region)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // interpolation model
  // ------------------------------------------------------------------------

  function automatic int eff_points();
    if (points_reg == 0) return 1;
    if (points_reg > TBL_DEPTH) return TBL_DEPTH;
    return int'(points_reg);
  endfunction

  function automatic interp_t interp_predict(
    input logic signed [pwli_pkg::DATA_W-1:0] qx);
    interp_t             r;
    int                  cnt;
    int                  lo;
    int                  hi;
    int                  mid;
    longint              x0;
    longint              x1;
    longint              y0;
    longint              y1;
    longint              dx;
    longint              dy;
    longint              den;
    longint              sum;
    longint unsigned     q;
    bit                  neg;
    cnt = eff_points();
    // halving search for the first breakpoint at or above the query
    lo = 0;
    hi = cnt;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (bp_x[mid] < qx) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) begin
      r.y      = bp_y[0];
      r.region = pwli_pkg::REGION_LOW;
    end else if (lo >= cnt) begin
      r.y      = bp_y[cnt-1];
      r.region = pwli_pkg::REGION_HIGH;
    end else begin
      x0  = bp_x[lo-1];
      x1  = bp_x[lo];
      y0  = bp_y[lo-1];
      y1  = bp_y[lo];
      dx  = longint'(qx) - x0;
      dy  = y1 - y0;
      den = x1 - x0;
      r.region = pwli_pkg::REGION_INTERIOR;
      if (den == 0) begin
        sum = y0;
      end else begin
        // sign-magnitude product and quotient, truncated toward zero
        neg = ((dx < 0) != (dy < 0)) != (den < 0);
        q = longint'(dx < 0 ? -dx : dx) * longint'(dy < 0 ? -dy : dy);
        q = q / longint'(den < 0 ? -den : den);
        if (q > 64'd2147483648) q = 64'd2147483648;
        sum = y0 + (neg ? -longint'(q) : longint'(q));
      end
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      r.y = sum[pwli_pkg::DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [pwli_pkg::DATA_W-1:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[pwli_pkg::DATA_W-1:0];
  endfunction

  // mostly back-to-back, sometimes a short gap, rarely a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ------------------------------------------------------------------------
  // checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string what,
                                 input logic [pwli_pkg::DATA_W-1:0] got,
                                 input logic [pwli_pkg::DATA_W-1:0] want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
  endtask

  // results are shown for one cycle and taken at the edge that ends it
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with no query pending", y_result, '0);
      end else begin
        oldest = expected_q.pop_front();
        if (y_result !== oldest.y)
          report_mismatch("y_result", y_result, oldest.y);
        if (region !== oldest.region)
          report_mismatch("region", {30'd0, region}, {30'd0, oldest.region});
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles < WATCHDOG_LIMIT) begin
      stall_cycles <= stall_cycles + 1;
    end else begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // driving
  // ------------------------------------------------------------------------

  // called at a rising edge; returns at the edge where the item transfer
  // happened, with start left high so a following item can go straight on
  task automatic send_item(input logic k, input logic [pwli_pkg::SLOT_W-1:0] slot,
                           input logic signed [pwli_pkg::DATA_W-1:0] x,
                           input logic signed [pwli_pkg::DATA_W-1:0] y,
                           input bit typed, input interp_t typed_res);
    start       <= 1'b1;
    kind        <= k;
    point_index <= slot;
    x_value     <= x;
    y_value     <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (k == pwli_pkg::KIND_LOAD) begin
      bp_x[slot] = x;
      bp_y[slot] = y;
    end else begin
      expected_q.push_back(typed ? typed_res : interp_predict(x));
    end
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // sender holds off until every pending query has answered
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  // count register is only written with the block idle
  task automatic write_points(input logic [pwli_pkg::NP_W-1:0] v);
    drain();
    num_points_we <= 1'b1;
    num_points    <= v;
    @(posedge clk);
    num_points_we <= 1'b0;
    points_reg = v;
  endtask

  function automatic void add_row(input row_op_t op,
                                  input logic [pwli_pkg::SLOT_W-1:0] slot,
                                  input logic signed [pwli_pkg::DATA_W-1:0] x,
                                  input logic signed [pwli_pkg::DATA_W-1:0] y,
                                  input bit typed,
                                  input logic signed [pwli_pkg::DATA_W-1:0] ey,
                                  input logic [1:0] er);
    stim_row_t row;
    row.op         = op;
    row.slot       = slot;
    row.x          = x;
    row.y          = y;
    row.typed      = typed;
    row.res.y      = ey;
    row.res.region = er;
    dir_rows.push_back(row);
  endfunction

  // one random phase: pick a count, rebuild the valid part of the table,
  // then fire queries at and around the breakpoints with a little noise
  task automatic run_phase();
    logic [pwli_pkg::NP_W-1:0]          npv;
    logic signed [pwli_pkg::DATA_W-1:0] xs [TBL_DEPTH];
    logic signed [pwli_pkg::DATA_W-1:0] tmp;
    logic signed [pwli_pkg::DATA_W-1:0] qx;
    longint                             a;
    longint                             b;
    int                                 cnt;
    int                                 shx;
    int                                 shy;
    int                                 style;
    int                                 k;
    int                                 j;
    bit                                 bursty;
    bit                                 desc;
    case ($urandom_range(0, 9))
      0:       npv = '0;
      1:       npv = pwli_pkg::NP_W'(1);
      2:       npv = pwli_pkg::NP_W'(TBL_DEPTH);
      3:       npv = pwli_pkg::NP_W'($urandom_range(TBL_DEPTH + 1, 31));
      default: npv = pwli_pkg::NP_W'($urandom_range(2, TBL_DEPTH));
    endcase
    write_points(npv);
    cnt    = eff_points();
    bursty = ($urandom_range(0, 3) == 0);
    // shared shift gives tables from full range down to a narrow cluster
    shx    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 24);
    shy    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 24);
    style  = $urandom_range(0, 9);
    for (k = 0; k < cnt; k++) xs[k] = $signed($urandom) >>> shx;
    if (style < 8) begin
      // ascending table, the usual case
      for (k = 1; k < cnt; k++) begin
        tmp = xs[k];
        j   = k - 1;
        while (j >= 0 && xs[j] > tmp) begin
          xs[j+1] = xs[j];
          j--;
        end
        xs[j+1] = tmp;
      end
      // repeated abscissa between neighbors
      if (style == 7 && cnt > 1) begin
        k     = $urandom_range(1, cnt - 1);
        xs[k] = xs[k-1];
      end
    end
    desc = $urandom_range(0, 1);
    for (k = 0; k < cnt; k++) begin
      j = desc ? cnt - 1 - k : k;
      send_item(pwli_pkg::KIND_LOAD, pwli_pkg::SLOT_W'(j), xs[j],
                $signed($urandom) >>> shy, 1'b0, '0);
      idle_gap(bursty ? 0 : pick_gap());
    end
    // loads past the valid count never reach the search
    if (cnt < TBL_DEPTH) begin
      repeat ($urandom_range(0, 2)) begin
        send_item(pwli_pkg::KIND_LOAD,
                  pwli_pkg::SLOT_W'($urandom_range(cnt, TBL_DEPTH - 1)), $urandom,
                  $urandom, 1'b0, '0);
        idle_gap(bursty ? 0 : pick_gap());
      end
    end
    repeat ($urandom_range(4, 24)) begin
      // stray reload of a live slot breaks the ordering
      if ($urandom_range(0, 9) == 0) begin
        send_item(pwli_pkg::KIND_LOAD, pwli_pkg::SLOT_W'($urandom_range(0, cnt - 1)),
                  $signed($urandom) >>> shx, $signed($urandom) >>> shy, 1'b0, '0);
        idle_gap(bursty ? 0 : pick_gap());
      end
      k = $urandom_range(0, cnt - 1);
      a = bp_x[k];
      case ($urandom_range(0, 6))
        0: qx = bp_x[k];
        1: qx = clamp32(a + 1);
        2: qx = clamp32(a - 1);
        3: begin
          qx = bp_x[k];
          if (k + 1 < cnt) begin
            b = bp_x[k+1];
            if (b > a)
              qx = clamp32(a + longint'({$urandom, $urandom} % longint'(b - a + 1)));
          end
        end
        4: qx = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
        default: qx = $signed($urandom) >>> $urandom_range(0, 24);
      endcase
      send_item(pwli_pkg::KIND_QUERY, pwli_pkg::SLOT_W'($urandom), qx, $urandom,
                1'b0, '0);
      if ($urandom_range(0, 29) == 0) drain();
      else idle_gap(bursty ? 0 : pick_gap());
    end
  endtask

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    start         = 1'b0;
    kind          = pwli_pkg::KIND_LOAD;
    point_index   = '0;
    x_value       = '0;
    y_value       = '0;
    num_points_we = 1'b0;
    num_points    = '0;
    errors        = 0;
    items_sent    = 0;
    points_reg    = pwli_pkg::NP_W'(1);
    for (int i = 0; i < TBL_DEPTH; i++) begin
      bp_x[i] = '0;
      bp_y[i] = '0;
    end

    // single point after reset: everything maps onto it
    add_row(ROW_LOAD,  0, 32'sh0000_0000, 32'sh0005_0000, 0, '0,
            pwli_pkg::REGION_INTERIOR);
    add_row(ROW_QUERY, 3, 32'sh8000_0000, 32'sh7fff_ffff, 1, 32'sh0005_0000,
            pwli_pkg::REGION_LOW);
    add_row(ROW_QUERY, 0, 32'sh0000_0000, 32'sh0000_0000, 1, 32'sh0005_0000,
            pwli_pkg::REGION_LOW);
    add_row(ROW_QUERY, 15, 32'sh7fff_ffff, 32'sh8000_0000, 1, 32'sh0005_0000,
            pwli_pkg::REGION_HIGH);
    // count of zero behaves as one
    add_row(ROW_POINTS, 0, 32'sd0, '0, 0, '0, pwli_pkg::REGION_INTERIOR);
    add_row(ROW_QUERY, 0, 32'sh0000_0001, 32'sh0000_0000, 1, 32'sh0005_0000,
            pwli_pkg::REGION_HIGH);
    // two points, slope of 5.0 from (0, 5.0) to (1.0, 10.0)
    add_row(ROW_LOAD,  1, 32'sh0001_0000, 32'sh000a_0000, 0, '0,
            pwli_pkg::REGION_INTERIOR);
    add_row(ROW_POINTS, 0, 32'sd2, '0, 0, '0, pwli_pkg::REGION_INTERIOR);
    add_row(ROW_QUERY, 5, 32'sh0000_8000, 32'sh1234_5678, 1, 32'sh0007_8000,
            pwli_pkg::REGION_INTERIOR);
    add_row(ROW_QUERY, 0, 32'sh0001_0000, 32'sh0000_0000, 1, 32'sh000a_0000,
            pwli_pkg::REGION_INTERIOR);
    add_row(ROW_QUERY, 0, 32'sh0001_0001, 32'sh0000_0000, 1, 32'sh000a_0000,
            pwli_pkg::REGION_HIGH);
    // full-range span, widest divisor and product
    add_row(ROW_LOAD,  0, 32'sh8000_0000, 32'sh8000_0000, 0, '0,
            pwli_pkg::REGION_INTERIOR);
    add_row(ROW_LOAD,  1, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, '0,
            pwli_pkg::REGION_INTERIOR);
    add_row(ROW_QUERY, 0, 32'sh0000_0000, 32'sh0000_0000, 0, '0,
            pwli_pkg::REGION_INTERIOR);
    add_row(ROW_QUERY, 0, 32'sh7fff_ffff, 32'sh0000_0000, 0, '0,
            pwli_pkg::REGION_INTERIOR);
    add_row(ROW_QUERY, 0, 32'sh8000_0001, 32'sh0000_0000, 0, '0,
            pwli_pkg::REGION_INTERIOR);
    // steepest falling line
    add_row(ROW_LOAD,  0, 32'sh8000_0000, 32'sh7fff_ffff, 0, '0,
            pwli_pkg::REGION_INTERIOR);
    add_row(ROW_LOAD,  1, 32'sh7fff_ffff, 32'sh8000_0000, 0, '0,
            pwli_pkg::REGION_INTERIOR);
    add_row(ROW_QUERY, 0, 32'sh1234_5678, 32'sh0000_0000, 0, '0,
            pwli_pkg::REGION_INTERIOR);
    // out-of-order table, search applied as is
    add_row(ROW_LOAD,  2, 32'shffff_0000, 32'sh0003_0000, 0, '0,
            pwli_pkg::REGION_INTERIOR);
    add_row(ROW_LOAD,  3, 32'sh0002_0000, 32'shfffe_0000, 0, '0,
            pwli_pkg::REGION_INTERIOR);
    add_row(ROW_POINTS, 0, 32'sd4, '0, 0, '0, pwli_pkg::REGION_INTERIOR);
    add_row(ROW_QUERY, 0, 32'sh0000_0000, 32'sh0000_0000, 0, '0,
            pwli_pkg::REGION_INTERIOR);
    add_row(ROW_QUERY, 0, 32'shfffe_0000, 32'sh0000_0000, 0, '0,
            pwli_pkg::REGION_INTERIOR);
    add_row(ROW_QUERY, 0, 32'sh0001_8000, 32'sh0000_0000, 0, '0,
            pwli_pkg::REGION_INTERIOR);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].op)
        ROW_POINTS: write_points(dir_rows[i].x[pwli_pkg::NP_W-1:0]);
        ROW_LOAD: send_item(pwli_pkg::KIND_LOAD, dir_rows[i].slot, dir_rows[i].x,
                            dir_rows[i].y, 1'b0, '0);
        default: send_item(pwli_pkg::KIND_QUERY, dir_rows[i].slot, dir_rows[i].x,
                           dir_rows[i].y, dir_rows[i].typed, dir_rows[i].res);
      endcase
      idle_gap(pick_gap());
    end

    while (items_sent < ITEM_TARGET) run_phase();

    // wait for the last results, then a quiet stretch for stray strobes
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
